// File: hdl/bpa_pkg.sv
// Shared constants, codes, state type and control structs of the bitmap page allocator.
package bpa_pkg;

	// Bitmap geometry
	localparam int MAP_PAGES = 65536;
	localparam int WORD_BITS = 64;
	localparam int MAP_WORDS = MAP_PAGES / WORD_BITS;
	localparam int WORD_AW   = $clog2(MAP_WORDS);
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int PAGE_W    = $clog2(MAP_PAGES) + 1;
	localparam int PNUM_W    = PAGE_W - 1;
	localparam int CNT_W     = PAGE_W + 1;
	localparam int PAGE_SHIFT = 12;
	localparam int ADDR_W    = 28;
	localparam int BYTES_W   = 29;

	// Request kinds
	localparam logic [1:0] KIND_ALLOC = 2'd0;
	localparam logic [1:0] KIND_FREE  = 2'd1;
	localparam logic [1:0] KIND_MARK  = 2'd2;

	// Register indexes
	localparam logic REG_MAP_END      = 1'b0;
	localparam logic REG_SEARCH_START = 1'b1;

	// Reset values of the registers
	localparam logic [16:0] MAP_END_RESET      = 17'd65536;
	localparam logic [15:0] SEARCH_START_RESET = 16'd256;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_MARK_RD,
		ST_MARK_WR,
		ST_DONE
	} bpa_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic clr_wr;
		logic load;
		logic scan_rd;
		logic scan_step;
		logic set_fail;
		logic mark_rd;
		logic mark_wr;
		logic res_load;
	} bpa_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic       clr_last;
		logic [1:0] kind;
		logic       pages_zero;
		logic       scan_empty;
		logic       found;
		logic       scan_end;
		logic       word_cross;
		logic       mark_done;
		logic       mark_last;
		logic       out_free;
	} bpa_stat_t;

endpackage

// File: hdl/bpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bpa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: hdl/bpa_datapath.sv
// Datapath: bitmap memory, scan and range-marking logic, and the result register.
module bpa_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bpa_pkg::bpa_cmd_t     cmd,
	output bpa_pkg::bpa_stat_t    stat,
	input  logic [1:0]            in_kind,
	input  logic [27:0]           in_address,
	input  logic [28:0]           in_byte_count,
	input  logic [16:0]           map_end_page,
	input  logic [15:0]           search_start_page,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  out_status,
	output logic [27:0]           out_start_address
);
	import bpa_pkg::*;

	// Request registers
	logic [1:0]        kind_q;
	logic [CNT_W-1:0]  pages_q;
	logic [PAGE_W-1:0] p_q;
	logic [PAGE_W-1:0] run_q;
	logic [PNUM_W-1:0] first_q;
	logic [PAGE_W-1:0] cur_q;
	logic [PAGE_W-1:0] end_q;
	logic [WORD_AW-1:0] clr_q;
	logic              res_fail_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic              out_valid_q;
	logic              out_status_q;
	logic [ADDR_W-1:0] out_addr_q;

	logic [WORD_BITS-1:0] rd_data;
	logic [WORD_BITS-1:0] wr_data;
	logic [WORD_BITS-1:0] mask;
	logic                 wr_en;
	logic [WORD_AW-1:0]   wr_addr;
	logic [WORD_AW-1:0]   rd_addr;
	logic [PAGE_W-1:0]    limit;
	logic [CNT_W-1:0]     in_pages;
	logic [CNT_W-1:0]     in_end;
	logic [PAGE_W-1:0]    in_end_cap;
	logic [PAGE_W-1:0]    next_base;

	// Scan evaluation results
	logic [PAGE_W-1:0] p_new;
	logic [PAGE_W-1:0] run_new;
	logic [PNUM_W-1:0] first_new;
	logic              found;

	bpa_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MAP_WORDS)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (cmd.scan_rd | cmd.mark_rd),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Scan limit is the smaller of the register and the map size.
	assign limit = (map_end_page > PAGE_W'(MAP_PAGES)) ? PAGE_W'(MAP_PAGES) : map_end_page;

	// Round the byte count up to pages and cap the range end at the map.
	assign in_pages   = CNT_W'((30'(in_byte_count) + 30'd4095) >> PAGE_SHIFT);
	assign in_end     = CNT_W'(in_address[ADDR_W-1:PAGE_SHIFT]) + in_pages;
	assign in_end_cap = (in_end > CNT_W'(MAP_PAGES)) ? PAGE_W'(MAP_PAGES) : in_end[PAGE_W-1:0];

	// One scan step: a whole uniform word at once, otherwise up to eight pages.
	always_comb begin
		logic [PAGE_W-1:0] pg;
		logic [PAGE_W-1:0] rn;
		logic [PNUM_W-1:0] fs;
		logic              go;
		logic              fnd;
		logic [3:0]        cnt;
		logic [CNT_W-1:0]  sum;
		logic              fast;

		rn   = run_q;
		fs   = first_q;
		go   = 1'b1;
		fnd  = 1'b0;
		cnt  = 4'd0;
		sum  = CNT_W'(run_q) + CNT_W'(WORD_BITS);
		fast = (p_q[BIT_W-1:0] == '0)
			&& ((CNT_W'(p_q) + CNT_W'(WORD_BITS)) <= CNT_W'(limit));
		for (int k = 0; k < 8; k++) begin
			pg = p_q + PAGE_W'(k);
			if (go && (pg < limit) && ((k == 0) || (pg[BIT_W-1:0] != '0))) begin
				cnt = cnt + 4'd1;
				if (!rd_data[pg[BIT_W-1:0]]) begin
					if (rn == '0) begin
						fs = pg[PNUM_W-1:0];
					end
					rn = rn + PAGE_W'(1);
					if (CNT_W'(rn) == pages_q) begin
						fnd = 1'b1;
						go  = 1'b0;
					end
				end else begin
					rn = '0;
				end
			end else begin
				go = 1'b0;
			end
		end
		p_new = p_q + PAGE_W'(cnt);
		if (fast && (rd_data == '1)) begin
			rn    = '0;
			fs    = first_q;
			fnd   = 1'b0;
			p_new = p_q + PAGE_W'(WORD_BITS);
		end else if (fast && (rd_data == '0)) begin
			fs    = (run_q == '0) ? p_q[PNUM_W-1:0] : first_q;
			fnd   = (sum >= pages_q);
			rn    = sum[PAGE_W-1:0];
			p_new = p_q + PAGE_W'(WORD_BITS);
		end
		run_new   = rn;
		first_new = fs;
		found     = fnd;
	end

	// Mask of the range bits that fall inside the current word.
	assign next_base = {cur_q[PAGE_W-1:BIT_W], {BIT_W{1'b0}}} + PAGE_W'(WORD_BITS);
	always_comb begin
		logic [WORD_BITS-1:0] m_lo;
		logic [WORD_BITS-1:0] m_hi;
		m_lo = {WORD_BITS{1'b1}} << cur_q[BIT_W-1:0];
		if (end_q >= next_base) begin
			m_hi = '1;
		end else begin
			m_hi = ~({WORD_BITS{1'b1}} << end_q[BIT_W-1:0]);
		end
		mask = m_lo & m_hi;
	end

	// Memory port selection.
	always_comb begin
		wr_en   = cmd.clr_wr | cmd.mark_wr;
		wr_addr = cmd.clr_wr ? clr_q : cur_q[PNUM_W-1:BIT_W];
		if (cmd.clr_wr) begin
			wr_data = '1;
		end else if (kind_q == KIND_FREE) begin
			wr_data = rd_data & ~mask;
		end else begin
			wr_data = rd_data | mask;
		end
		rd_addr = cmd.scan_rd ? p_q[PNUM_W-1:BIT_W] : cur_q[PNUM_W-1:BIT_W];
	end

	// Clearing pass counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + WORD_AW'(1);
		end
	end

	// Request, scan and marking registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q     <= in_kind;
			pages_q    <= in_pages;
			p_q        <= {1'b0, search_start_page};
			run_q      <= '0;
			first_q    <= '0;
			cur_q      <= PAGE_W'(in_address[ADDR_W-1:PAGE_SHIFT]);
			end_q      <= in_end_cap;
			res_fail_q <= 1'b0;
			res_addr_q <= '0;
		end else begin
			if (cmd.set_fail) begin
				res_fail_q <= 1'b1;
			end
			if (cmd.scan_step) begin
				p_q     <= p_new;
				run_q   <= run_new;
				first_q <= first_new;
				if (found) begin
					cur_q      <= {1'b0, first_new};
					end_q      <= {1'b0, first_new} + pages_q[PAGE_W-1:0];
					res_addr_q <= {first_new, {PAGE_SHIFT{1'b0}}};
				end
			end
			if (cmd.mark_wr) begin
				cur_q <= next_base;
			end
		end
	end

	// Result register; a finished result waits here while the next request runs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_status_q <= res_fail_q;
			out_addr_q   <= res_addr_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign out_status        = out_status_q;
	assign out_start_address = out_addr_q;

	// Status toward the controller.
	always_comb begin
		stat.clr_last   = (clr_q == WORD_AW'(MAP_WORDS - 1));
		stat.kind       = kind_q;
		stat.pages_zero = (pages_q == '0);
		stat.scan_empty = ({1'b0, search_start_page} >= limit);
		stat.found      = found;
		stat.scan_end   = !found && (p_new >= limit);
		stat.word_cross = (p_new[BIT_W-1:0] == '0);
		stat.mark_done  = (cur_q >= end_q);
		stat.mark_last  = (next_base >= end_q);
		stat.out_free   = !out_valid_q || out_ready;
	end

endmodule

// File: hdl/bpa_ctrl.sv
// Controller state machine that sequences clearing, scanning, marking and results.
module bpa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bpa_pkg::bpa_stat_t stat,
	output bpa_pkg::bpa_cmd_t  cmd
);
	import bpa_pkg::*;

	bpa_state_t state_q;
	bpa_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (stat.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				case (stat.kind)
					KIND_ALLOC: begin
						if (stat.pages_zero || stat.scan_empty) state_d = ST_DONE;
						else state_d = ST_SCAN_RD;
					end
					KIND_FREE, KIND_MARK: begin
						if (stat.mark_done) state_d = ST_DONE;
						else state_d = ST_MARK_RD;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_SCAN_RD: state_d = ST_SCAN_EV;
			ST_SCAN_EV: begin
				if (stat.found) state_d = ST_MARK_RD;
				else if (stat.scan_end) state_d = ST_DONE;
				else if (stat.word_cross) state_d = ST_SCAN_RD;
			end
			ST_MARK_RD: state_d = ST_MARK_WR;
			ST_MARK_WR: begin
				if (stat.mark_last) state_d = ST_DONE;
				else state_d = ST_MARK_RD;
			end
			ST_DONE: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_INIT: cmd.clr_wr = 1'b1;
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DECODE: begin
				cmd.set_fail = (stat.kind == KIND_ALLOC) && (stat.pages_zero || stat.scan_empty);
			end
			ST_SCAN_RD: cmd.scan_rd = 1'b1;
			ST_SCAN_EV: begin
				cmd.scan_step = 1'b1;
				cmd.set_fail  = stat.scan_end;
			end
			ST_MARK_RD: cmd.mark_rd = 1'b1;
			ST_MARK_WR: cmd.mark_wr = 1'b1;
			ST_DONE:    cmd.res_load = stat.out_free;
			default: ;
		endcase
	end

endmodule

// File: hdl/bitmap_page_allocator.sv
// Top level of the bitmap page allocator: ports, configuration registers and wiring.
//
//   Channel   Direction  Handshake          Contents
//   s_*       in         s_tvalid/s_tready  request: kind, address, byte_count
//   m_*       out        m_tvalid/m_tready  result: status, start_address
//   APB       in/out     psel/penable       map_end_page, search_start_page
//
// After reset a clearing pass writes all ones over the 1024 bitmap words, and
// no request is accepted during it.
// Free and mark used read and then write each bitmap word that the range touches.
// Alloc reads each word and takes it whole where it is all free or all used, or
// up to 8 pages per cycle where it is mixed; then the run is marked.
// The result register holds one finished result, so a stalled output stalls
// only the next request's completion, not its acceptance.
module bitmap_page_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [27:0] address, [56:28] byte_count, zero above
	input  logic [1:0]  s_tuser,   // [1:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [27:0] start_address, zero above
	output logic [0:0]  m_tuser,   // [0] status
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bpa_pkg::*;

	logic [16:0] map_end_q;
	logic [15:0] search_start_q;
	logic        cfg_wr;
	logic        out_status;
	logic [27:0] out_addr;
	bpa_cmd_t    cmd;
	bpa_stat_t   stat;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_end_q      <= MAP_END_RESET;
			search_start_q <= SEARCH_START_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_MAP_END:      map_end_q      <= pwdata[16:0];
				REG_SEARCH_START: search_start_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (paddr[2])
			REG_MAP_END:      prdata = {15'd0, map_end_q};
			REG_SEARCH_START: prdata = {16'd0, search_start_q};
			default:          prdata = '0;
		endcase
	end

	bpa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	bpa_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.in_kind          (s_tuser),
		.in_address       (s_tdata[27:0]),
		.in_byte_count    (s_tdata[56:28]),
		.map_end_page     (map_end_q),
		.search_start_page(search_start_q),
		.out_valid        (m_tvalid),
		.out_ready        (m_tready),
		.out_status       (out_status),
		.out_start_address(out_addr)
	);

	assign m_tdata = {4'd0, out_addr};
	assign m_tuser = out_status;

endmodule

// File: hdl/bpa_checker.sv
// Port-level checker for the bitmap page allocator and its bind statement.
module bpa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// A failed alloc reports a zero address.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[27:0] == 28'd0)
		else $error("failed request carries an address");

	// Returned addresses are page aligned.
	a_page_align: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[11:0] == 12'd0)
		else $error("start address not page aligned");

	// One request at a time: the block is busy right after accepting one.
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted in back-to-back cycles");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
